// ===== rtl/core/indexed_insert_remove_list_unit_macros.svh =====
// Assertion helpers for the checker file.
`ifndef INDEXED_INSERT_REMOVE_LIST_UNIT_MACROS_SVH
`define INDEXED_INSERT_REMOVE_LIST_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define IIRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define IIRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/iirl_pkg.sv =====
`default_nettype none

package iirl_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int OP_W     = 3;
  localparam int INDEX_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 3'd0,
    OP_READ      = 3'd1,
    OP_APPEND    = 3'd2,
    OP_REMOVE_LAST = 3'd3,
    OP_INSERT    = 3'd4,
    OP_REMOVE_AT = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Broadcast to every cell for one request.
  typedef struct packed {
    logic load;   // cell at pos takes the request value
    logic open;   // cells above pos up to count take their lower neighbor
    logic close;  // cells from pos below count-1 take their upper neighbor
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/indexed_insert_remove_list_unit.sv =====
// Bounded ordered list of 32-bit words held in a row of DEPTH cells, one word
// per cell, plus an element count. Each request carries an op (write, read,
// append, remove last, insert at index, remove at index), an index and a
// value, and yields exactly one result: the word read or removed, a status
// (ok, full, empty, index out of range) and the element count after the op.
// A failing request leaves the list untouched; unused op codes return ok with
// the count unchanged. Insert and remove at index move every later word one
// cell in the same clock, since each cell loads from its neighbor, so one
// request is accepted per cycle: the result lands in an output register the
// cycle after acceptance, and a new request is taken while that result is
// being taken. The only stall is a result still held on the output. After
// reset the list is empty; no clearing pass is needed since only cells below
// the count are ever read.
`default_nettype none

module indexed_insert_remove_list_unit #(
  parameter int DEPTH = iirl_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [iirl_pkg::OP_W-1:0]     in_op,
  input  wire logic [iirl_pkg::INDEX_W-1:0]  in_index,
  input  wire logic [iirl_pkg::VALUE_W-1:0]  in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [iirl_pkg::VALUE_W-1:0]       out_read_value,
  output logic [iirl_pkg::STATUS_W-1:0]      out_status,
  output logic [iirl_pkg::COUNT_W-1:0]       out_count
);
  import iirl_pkg::*;

  // Wide enough for the count (up to DEPTH) and for any request index.
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int POS_W = (CW > INDEX_W + 1) ? CW : INDEX_W + 1;
  localparam logic [POS_W-1:0] FULL_CNT = POS_W'(DEPTH);
  localparam logic [POS_W-1:0] ONE      = POS_W'(1);

  logic [POS_W-1:0] count_r, count_nxt;

  logic                    out_valid_r;
  logic [VALUE_W-1:0]      out_read_value_r;
  status_t                 out_status_r;
  logic [COUNT_W-1:0]      out_count_r;

  logic          accept;
  op_t           op;
  logic [POS_W-1:0] idx;
  status_t       status;
  cell_cmd_t     cmd;
  logic [POS_W-1:0] pos;
  logic          rd_en;
  logic [POS_W-1:0] rd_pos;
  logic [VALUE_W-1:0] rd_word;

  logic [VALUE_W-1:0] cell_data [DEPTH];
  logic [VALUE_W-1:0] cell_rd   [DEPTH];

  // Take a new request whenever the output register is free or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign op  = op_t'(in_op);
  assign idx = POS_W'(in_index);

  // Decode: checks, cell command, count update and read selection.
  always_comb begin
    status    = ST_OK;
    cmd       = '0;
    pos       = idx;
    rd_en     = 1'b0;
    rd_pos    = idx;
    count_nxt = count_r;
    case (op)
      OP_WRITE: begin
        if (idx < count_r) cmd.load = 1'b1;
        else               status   = ST_RANGE;
      end
      OP_READ: begin
        if (idx < count_r) rd_en  = 1'b1;
        else               status = ST_RANGE;
      end
      OP_APPEND: begin
        // Append is an insert at the end: nothing moves.
        if (count_r >= FULL_CNT) begin
          status = ST_FULL;
        end else begin
          pos       = count_r;
          cmd.load  = 1'b1;
          count_nxt = count_r + ONE;
        end
      end
      OP_REMOVE_LAST: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_pos    = count_r - ONE;
          count_nxt = count_r - ONE;
        end
      end
      OP_INSERT: begin
        if (count_r >= FULL_CNT) begin
          status = ST_FULL;
        end else if (idx > count_r) begin
          status = ST_RANGE;
        end else begin
          cmd.load  = 1'b1;
          cmd.open  = 1'b1;
          count_nxt = count_r + ONE;
        end
      end
      OP_REMOVE_AT: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (idx >= count_r) begin
          status = ST_RANGE;
        end else begin
          rd_en     = 1'b1;
          cmd.close = 1'b1;
          count_nxt = count_r - ONE;
        end
      end
      default: begin
        // Unused codes: report ok, change nothing.
      end
    endcase
    // Hold the cells unless the request is actually taken.
    if (!accept) cmd = '0;
  end

  // Row of cells; each sees its neighbors' words for shifting.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = cell_data[i+1];
    end
    iirl_cell #(
      .POS_W (POS_W),
      .SLOT  (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (pos),
      .count     (count_r),
      .value     (in_value),
      .prev_data (prev_w),
      .next_data (next_w),
      .rd_en     (rd_en),
      .rd_pos    (rd_pos),
      .data      (cell_data[i]),
      .rd_data   (cell_rd[i])
    );
  end

  // At most one cell drives a nonzero read word; merge them.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: advance only on an accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_value_r <= rd_word;
      out_status_r     <= status;
      out_count_r      <= count_nxt[COUNT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

endmodule

`default_nettype wire

// ===== rtl/core/iirl_cell.sv =====
`default_nettype none

module iirl_cell #(
  parameter int POS_W = 7,
  parameter int SLOT  = 0
) (
  input  wire logic                         clk,
  input  wire iirl_pkg::cell_cmd_t          cmd,
  input  wire logic [POS_W-1:0]             pos,
  input  wire logic [POS_W-1:0]             count,
  input  wire logic [iirl_pkg::VALUE_W-1:0] value,
  input  wire logic [iirl_pkg::VALUE_W-1:0] prev_data,
  input  wire logic [iirl_pkg::VALUE_W-1:0] next_data,
  input  wire logic                         rd_en,
  input  wire logic [POS_W-1:0]             rd_pos,
  output logic      [iirl_pkg::VALUE_W-1:0] data,
  output logic      [iirl_pkg::VALUE_W-1:0] rd_data
);
  import iirl_pkg::*;

  localparam logic [POS_W-1:0] MY_POS   = POS_W'(SLOT);
  localparam logic [POS_W-1:0] MY_POS_1 = POS_W'(SLOT + 1);

  logic [VALUE_W-1:0] data_r;
  logic [VALUE_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.load && (MY_POS == pos)) begin
      data_nxt = value;
    end else if (cmd.open && (MY_POS > pos) && (MY_POS <= count)) begin
      data_nxt = prev_data;
    end else if (cmd.close && (MY_POS >= pos) && (MY_POS_1 < count)) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (rd_en && (MY_POS == rd_pos)) ? data_r : '0;

endmodule

`default_nettype wire

// ===== rtl/core/iirl_checker.sv =====
`default_nettype none

`include "indexed_insert_remove_list_unit_macros.svh"

module iirl_checker #(
  parameter int DEPTH = iirl_pkg::DEPTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [iirl_pkg::VALUE_W-1:0]  out_read_value,
  input wire logic [iirl_pkg::STATUS_W-1:0] out_status,
  input wire logic [iirl_pkg::COUNT_W-1:0]  out_count
);
  import iirl_pkg::*;

  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

  logic in_fire;
  logic out_hold;
  logic err_empty;
  logic err_full;
  logic empty_clean;

  assign in_fire     = in_valid && in_ready;
  assign out_hold    = out_valid && !out_ready;
  assign err_empty   = out_valid && (out_status == ST_EMPTY);
  assign err_full    = out_valid && (out_status == ST_FULL);
  assign empty_clean = (out_count == '0) && (out_read_value == '0);

  // A request accepted now always produces a result next cycle.
  `IIRL_ASSERT(a_req_gives_result, in_fire |=> out_valid, "request lost")

  // A result not taken stays on the output.
  `IIRL_ASSERT(a_result_holds, out_hold |=> (out_valid && $stable(out_count)), "result dropped")

  // An empty-list error only happens with nothing stored.
  `IIRL_ASSERT(a_empty_count, err_empty |-> empty_clean, "empty status with elements")

  // A full-list error only happens at capacity.
  `IIRL_ASSERT(a_full_count, err_full |-> (out_count == FULL_CNT), "full status below capacity")

  // No result is shown right after reset.
  `IIRL_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result after reset")

endmodule

bind indexed_insert_remove_list_unit iirl_checker #(.DEPTH(DEPTH)) u_iirl_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
module tb;
  import iirl_pkg::*;

  // Op codes the block decodes as no-ops; they still return one reply.
  localparam logic [OP_W-1:0] OP_UNUSED6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED7 = 3'd7;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int TARGET_REQS  = 550;
  localparam int STALL_LIMIT  = 2000;   // cycles with no handshake on either side
  localparam int IDLE_PCT     = 30;
  localparam int CALM_FIRST   = 250;    // handshake count where the no-idle stretch starts
  localparam int CALM_LAST    = 350;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    bit                 drain;    // hold this request until every reply is back
  } list_req_t;

  typedef struct {
    logic [VALUE_W-1:0] read_value;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } list_reply_t;

  // Ports; every input starts at a known value.
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_op = '0;
  logic [INDEX_W-1:0] in_index = '0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [VALUE_W-1:0] out_read_value;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0] out_count;

  // Request source, predicted replies and the predictor's copy of the list.
  list_req_t          req_q[$];
  list_reply_t        reply_q[$];
  logic [VALUE_W-1:0] list_words [LIST_DEPTH];
  int                 list_len = 0;
  int                 gen_len = 0;      // length the generator expects, to shape sequences

  int mismatches = 0;
  int reqs_sent = 0;
  int replies_seen = 0;
  int in_flight = 0;
  int stall_cycles = 0;
  int status_hits [4] = '{0, 0, 0, 0};
  int unused_ops = 0;
  int peak_len = 0;

  indexed_insert_remove_list_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Queue one request and advance the generator's idea of the list length.
  task automatic add_req(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                         input logic [VALUE_W-1:0] val, input bit drain);
    list_req_t r;
    r = '{op: op, index: idx, value: val, drain: drain};
    req_q.push_back(r);
    case (op)
      OP_APPEND:      if (gen_len < LIST_DEPTH) gen_len++;
      OP_INSERT:      if (gen_len < LIST_DEPTH && int'(idx) <= gen_len) gen_len++;
      OP_REMOVE_LAST: if (gen_len > 0) gen_len--;
      OP_REMOVE_AT:   if (gen_len > 0 && int'(idx) < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // Work out the reply for one accepted request and update the list copy.
  function automatic list_reply_t predict_reply(list_req_t r);
    list_reply_t rep;
    int          idx;
    int          k;
    idx = int'(r.index);
    rep.read_value = '0;
    rep.status = ST_OK;
    case (r.op)
      OP_WRITE: begin
        if (idx < list_len) list_words[idx] = r.value;
        else rep.status = ST_RANGE;
      end
      OP_READ: begin
        if (idx < list_len) rep.read_value = list_words[idx];
        else rep.status = ST_RANGE;
      end
      OP_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          list_words[list_len] = r.value;
          list_len++;
        end
      end
      OP_REMOVE_LAST: begin
        if (list_len == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          list_len--;
          rep.read_value = list_words[list_len];
        end
      end
      OP_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          rep.status = ST_FULL;
        end else if (idx > list_len) begin
          rep.status = ST_RANGE;
        end else begin
          // Open a hole at idx by moving the tail up one word.
          for (k = list_len; k > idx; k--) list_words[k] = list_words[k-1];
          list_words[idx] = r.value;
          list_len++;
        end
      end
      OP_REMOVE_AT: begin
        if (list_len == 0) begin
          rep.status = ST_EMPTY;
        end else if (idx >= list_len) begin
          rep.status = ST_RANGE;
        end else begin
          rep.read_value = list_words[idx];
          list_len--;
          // Close the gap by moving the tail down one word.
          for (k = idx; k < list_len; k++) list_words[k] = list_words[k+1];
        end
      end
      default: ;
    endcase
    rep.count = COUNT_W'(list_len);
    return rep;
  endfunction

  // Driver: present queued requests, holding each until accepted. Skip cycles
  // at random outside the calm stretch, and hold a drain-marked request back
  // until nothing is in flight.
  always @(posedge clk) begin : driver
    list_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_op    <= '0;
      in_index <= '0;
      in_value <= '0;
    end else begin
      if (in_valid && in_ready) begin
        reqs_sent++;
        in_flight++;
      end
      if (out_valid && out_ready) in_flight--;
      // A request that is still waiting keeps valid and payload as they are.
      if (!in_valid || in_ready) begin
        if (req_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (req_q[0].drain && in_flight != 0) begin
          in_valid <= 1'b0;
        end else if (!(reqs_sent >= CALM_FIRST && reqs_sent < CALM_LAST) &&
                     $urandom_range(99) < IDLE_PCT) begin
          in_valid <= 1'b0;
        end else begin
          nxt = req_q.pop_front();
          in_valid <= 1'b1;
          in_op    <= nxt.op;
          in_index <= nxt.index;
          in_value <= nxt.value;
        end
      end
    end
  end

  // Monitor: check each reply against the oldest prediction first, then
  // predict the reply for any request accepted at this same edge, so the
  // order of the two never depends on scheduling.
  always @(posedge clk) begin : monitor
    list_reply_t want;
    list_req_t   seen;
    if (!rst_n) begin
      out_ready    <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("reply with no request pending: value %h status %0d count %0d",
                                    out_read_value, out_status, out_count));
        end else begin
          want = reply_q.pop_front();
          status_hits[want.status]++;
          if (out_read_value !== want.read_value)
            report_mismatch($sformatf("reply %0d read_value %h, want %h",
                                      replies_seen, out_read_value, want.read_value));
          if (out_status !== want.status)
            report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                      replies_seen, out_status, want.status));
          if (out_count !== want.count)
            report_mismatch($sformatf("reply %0d count %0d, want %0d",
                                      replies_seen, out_count, want.count));
        end
      end
      if (in_valid && in_ready) begin
        seen = '{op: in_op, index: in_index, value: in_value, drain: 1'b0};
        if (in_op == OP_UNUSED6 || in_op == OP_UNUSED7) unused_ops++;
        reply_q.push_back(predict_reply(seen));
        if (list_len > peak_len) peak_len = list_len;
      end
      // Watchdog: count cycles where neither channel moves anything.
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      // Stall the reply side at random, except in the calm stretch.
      out_ready <= (replies_seen >= CALM_FIRST && replies_seen < CALM_LAST) ||
                   ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : run_ctl
    int  kind;
    int  n;
    int  first_seg;
    logic [OP_W-1:0] op;
    bit  timed_out;

    // Directed: empty-list errors, edge values, insert at the end, inserts
    // and removes in the middle, index past the end, unused op codes.
    add_req(OP_READ,        6'd0,  32'h0,         1'b0);
    add_req(OP_WRITE,       6'd0,  32'hFFFF_FFFF, 1'b0);
    add_req(OP_REMOVE_LAST, 6'd0,  32'h0,         1'b0);
    add_req(OP_REMOVE_AT,   6'd63, 32'h0,         1'b0);
    add_req(OP_INSERT,      6'd1,  $urandom,      1'b0);
    add_req(OP_INSERT,      6'd0,  32'hFFFF_FFFF, 1'b0);
    add_req(OP_APPEND,      6'd0,  32'h0,         1'b0);
    add_req(OP_INSERT,      6'd2,  32'h8000_0001, 1'b0);
    add_req(OP_INSERT,      6'd1,  32'hA5A5_5A5A, 1'b0);
    add_req(OP_INSERT,      6'd63, $urandom,      1'b0);
    add_req(OP_WRITE,       6'd3,  32'h0000_0001, 1'b0);
    add_req(OP_WRITE,       6'd4,  $urandom,      1'b0);
    add_req(OP_READ,        6'd0,  32'h0,         1'b0);
    add_req(OP_READ,        6'd3,  32'h0,         1'b0);
    add_req(OP_READ,        6'd1,  32'h0,         1'b0);
    add_req(OP_READ,        6'd63, 32'h0,         1'b0);
    add_req(OP_UNUSED6,     6'd63, 32'hFFFF_FFFF, 1'b0);
    add_req(OP_UNUSED7,     6'd0,  32'h0,         1'b0);
    add_req(OP_REMOVE_AT,   6'd1,  32'h0,         1'b0);
    add_req(OP_REMOVE_AT,   6'd3,  32'h0,         1'b0);
    add_req(OP_REMOVE_AT,   6'd2,  32'h0,         1'b0);
    add_req(OP_REMOVE_LAST, 6'd0,  32'h0,         1'b0);
    add_req(OP_REMOVE_LAST, 6'd0,  32'h0,         1'b0);

    // Random: fill to full, drain to empty and mixed runs of mostly legal
    // requests. The first segment is a fill, so the full case always shows.
    first_seg = 1;
    while (req_q.size() < TARGET_REQS) begin
      kind = first_seg ? 0 : $urandom_range(9);
      // Pause the sender now and then until every reply is back.
      if (first_seg || $urandom_range(3) == 0)
        add_req(OP_READ, INDEX_W'($urandom_range(63)), $urandom, 1'b1);
      first_seg = 0;
      if (kind <= 2) begin
        while (gen_len < LIST_DEPTH)
          add_req($urandom_range(1) ? OP_APPEND : OP_INSERT,
                  INDEX_W'($urandom_range(gen_len)), $urandom, 1'b0);
        add_req(OP_APPEND, INDEX_W'($urandom_range(63)), $urandom, 1'b0);
        add_req(OP_INSERT, INDEX_W'($urandom_range(63)), $urandom, 1'b0);
      end else if (kind <= 4) begin
        while (gen_len > 0)
          if ($urandom_range(1)) add_req(OP_REMOVE_LAST, INDEX_W'($urandom_range(63)),
                                         $urandom, 1'b0);
          else add_req(OP_REMOVE_AT, INDEX_W'($urandom_range(gen_len - 1)), $urandom, 1'b0);
        add_req(OP_REMOVE_LAST, INDEX_W'($urandom_range(63)), $urandom, 1'b0);
        add_req(OP_REMOVE_AT, INDEX_W'($urandom_range(63)), $urandom, 1'b0);
      end else begin
        n = $urandom_range(40, 20);
        repeat (n) begin
          if ($urandom_range(99) < 15) begin
            // Noise: any op code, any index.
            add_req(OP_W'($urandom_range(7)), INDEX_W'($urandom_range(63)), $urandom, 1'b0);
          end else begin
            op = OP_W'($urandom_range(5));
            if (op == OP_INSERT || op == OP_APPEND)
              add_req(op, INDEX_W'($urandom_range(gen_len)), $urandom, 1'b0);
            else
              add_req(op, INDEX_W'(gen_len > 0 ? $urandom_range(gen_len - 1) : 0),
                      $urandom, 1'b0);
          end
        end
      end
    end

    // Hold reset, then release it for good.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last request and its reply, or for the watchdog.
    while (!(req_q.size() == 0 && !in_valid && reply_q.size() == 0) &&
           stall_cycles < STALL_LIMIT)
      @(negedge clk);
    timed_out = (stall_cycles >= STALL_LIMIT);

    if (timed_out) begin
      $display("Timeout: no handshake for %0d cycles, %0d requests sent, %0d replies",
               STALL_LIMIT, reqs_sent, replies_seen);
      $display("** indexed_insert_remove_list_unit: FAILED **");
    end else begin
      // Give a stray extra reply a chance to show up.
      repeat (8) @(posedge clk);
      @(negedge clk);
      if (reply_q.size() != 0)
        report_mismatch($sformatf("%0d replies never arrived", reply_q.size()));
      $display("Covered %0d requests (%0d with unused op codes); replies ok %0d, full %0d,",
               reqs_sent, unused_ops, status_hits[ST_OK], status_hits[ST_FULL]);
      $display("  empty %0d, out of range %0d; list grew to %0d of %0d words",
               status_hits[ST_EMPTY], status_hits[ST_RANGE], peak_len, LIST_DEPTH);
      if (mismatches == 0) begin
        $display("** indexed_insert_remove_list_unit: PASSED **");
      end else begin
        $display("** indexed_insert_remove_list_unit: FAILED **");
      end
    end
    $finish;
  end

endmodule
